@@ sv/ile_pkg.sv @@
`timescale 1ns / 1ps
// shared types and codes for the indexed list engine
// no dependencies; used by the channel interfaces, the cell and the top level
package ile_pkg;

  localparam int REQ_W    = 3;
  localparam int PMODE_W  = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int RIDX_W   = 6;
  localparam int CNT_W    = 7;
  localparam int KEY_HALF_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_APPEND     = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_FIND       = 3'd3,
    REQ_CHANGE     = 3'd4,
    REQ_GET        = 3'd5,
    REQ_TAKE       = 3'd6,
    REQ_POP        = 3'd7
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NOT_IN_LIST = 2'd1,
    STAT_FULL        = 2'd2
  } status_t;

  localparam logic [PMODE_W-1:0] PMODE_FIRST = 2'd1;
  localparam logic [PMODE_W-1:0] PMODE_LAST  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_SHIFT_DOWN = 2'd1,
    CELL_OPEN       = 2'd2,
    CELL_WRITE      = 2'd3
  } cell_op_t;

endpackage

@@ sv/ile_in_if.sv @@
`timescale 1ns / 1ps
// request channel of the indexed list engine: valid/ready plus request payload
// depends on ile_pkg for field widths
interface ile_in_if;
  logic                           valid;
  logic                           ready;
  logic [ile_pkg::REQ_W-1:0]      req_type;
  logic [ile_pkg::PMODE_W-1:0]    position_mode;
  logic [ile_pkg::POS_W-1:0]      position;
  logic [ile_pkg::DATA_W-1:0]     entry_data;
  logic [ile_pkg::DATA_W-1:0]     search_key;

  modport source (
    output valid, req_type, position_mode, position, entry_data, search_key,
    input  ready
  );

  modport sink (
    input  valid, req_type, position_mode, position, entry_data, search_key,
    output ready
  );
endinterface

@@ sv/ile_out_if.sv @@
`timescale 1ns / 1ps
// result channel of the indexed list engine: valid/ready plus result payload
// depends on ile_pkg for field widths
interface ile_out_if;
  logic                           valid;
  logic                           ready;
  logic [ile_pkg::STATUS_W-1:0]   status;
  logic [ile_pkg::RIDX_W-1:0]     result_index;
  logic [ile_pkg::DATA_W-1:0]     result_data;
  logic [ile_pkg::CNT_W-1:0]      entry_count;

  modport source (
    output valid, status, result_index, result_data, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, result_index, result_data, entry_count,
    output ready
  );
endinterface

@@ sv/indexed_list_engine.sv @@
`timescale 1ns / 1ps
// indexed list engine top level: control sequencer, ring of record cells, output register
// depends on ile_pkg, ile_in_if, ile_out_if and ile_cell
//
// usage
//   in_ch carries one request per beat (valid/ready); out_ch returns exactly one
//   result beat per request, in order. cfg_we/cfg_wdata set the find key width
//   (0 = low 32 bits, 1 = low 16 bits); write it only while the block is idle.
//   records live in a ring of LIST_DEPTH cells. push, append, insert and change
//   update the ring in the accept cycle. find, get, take and pop rotate the
//   ring once past the head cell; take and pop then close the gap in a further step.
//   one request is worked on at a time; in_ch.ready is high while idle.
//   the result sits in an output register, so a new request is taken while a
//   stalled result waits; the following result is held back until out_ch drains.
//   reset (rst_n low, synchronous) empties the list, clears the config bit and
//   drops any pending result; record contents are not cleared.
module indexed_list_engine #(
  parameter int LIST_DEPTH   = 64,
  parameter int RECORD_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  ile_in_if.sink           in_ch,
  ile_out_if.source        out_ch
);

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
  localparam logic [IW-1:0] LAST_IDX  = IW'(LIST_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(LIST_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_CLOSE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    kcm_r;
  ile_pkg::req_t           req_r, req_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [ile_pkg::DATA_W-1:0] key_r, key_nxt;
  logic [IW-1:0]           scan_r, scan_nxt;
  logic                    found_r, found_nxt;
  ile_pkg::status_t        res_status_r, res_status_nxt;
  logic [IW-1:0]           res_idx_r, res_idx_nxt;
  logic [ile_pkg::DATA_W-1:0] res_data_r, res_data_nxt;

  logic                    out_vld_r, out_vld_nxt;
  logic [ile_pkg::STATUS_W-1:0] out_status_r;
  logic [ile_pkg::RIDX_W-1:0]   out_idx_r;
  logic [ile_pkg::DATA_W-1:0]   out_data_r;
  logic [ile_pkg::CNT_W-1:0]    out_cnt_r;
  logic                    out_load;

  logic                    accept;
  logic [PW-1:0]           rp;
  logic                    rp_ok;
  logic [PW-1:0]           pcnt;
  logic                    full;
  logic                    hit;
  logic                    key_eq;

  ile_pkg::cell_op_t       cell_op;
  logic [IW-1:0]           cell_idx;
  logic [RECORD_WIDTH-1:0] wr_rec;
  logic [RECORD_WIDTH-1:0] rec [LIST_DEPTH];
  logic [ile_pkg::DATA_W-1:0] head32;

  // ring of cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    ile_cell #(
      .IDX_W        (IW),
      .RECORD_WIDTH (RECORD_WIDTH),
      .CELL_IDX     (i)
    ) u_cell (
      .clk      (clk),
      .op       (cell_op),
      .sel_idx  (cell_idx),
      .wr_data  (wr_rec),
      .prev_rec (rec[(i + LIST_DEPTH - 1) % LIST_DEPTH]),
      .next_rec (rec[(i + 1) % LIST_DEPTH]),
      .rec      (rec[i])
    );
  end

  for (genvar b = 0; b < RECORD_WIDTH; b++) begin : g_wr_bit
    if (b < ile_pkg::DATA_W) begin : g_data
      assign wr_rec[b] = in_ch.entry_data[b];
    end else begin : g_zero
      assign wr_rec[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < ile_pkg::DATA_W; b++) begin : g_head_bit
    if (b < RECORD_WIDTH) begin : g_rec
      assign head32[b] = rec[0][b];
    end else begin : g_zero
      assign head32[b] = 1'b0;
    end
  end

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign full = (count_r == DEPTH_CNT);
  assign pcnt = PW'(count_r);

  // position resolution
  always_comb begin
    rp    = PW'(in_ch.position);
    rp_ok = 1'b1;
    case (in_ch.position_mode)
      ile_pkg::PMODE_FIRST: rp = '0;
      ile_pkg::PMODE_LAST: begin
        rp    = pcnt - PW'(1);
        rp_ok = (count_r != '0);
      end
      default: rp = PW'(in_ch.position);
    endcase
  end

  assign key_eq = kcm_r ? (head32[ile_pkg::KEY_HALF_W-1:0] == key_r[ile_pkg::KEY_HALF_W-1:0])
                        : (head32 == key_r);
  assign hit = (req_r == ile_pkg::REQ_FIND) ? ((CW'(scan_r) < count_r) && key_eq)
                                            : (scan_r == idx_r);
  assign out_load = (state_r == ST_EMIT) && (!out_vld_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    scan_nxt       = scan_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_data_nxt   = res_data_r;
    cell_op        = ile_pkg::CELL_HOLD;
    cell_idx       = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt        = ile_pkg::req_t'(in_ch.req_type);
          key_nxt        = in_ch.search_key;
          res_status_nxt = ile_pkg::STAT_NOT_IN_LIST;
          res_idx_nxt    = '0;
          res_data_nxt   = '0;
          found_nxt      = 1'b0;
          scan_nxt       = '0;
          state_nxt      = ST_EMIT;
          case (ile_pkg::req_t'(in_ch.req_type))
            ile_pkg::REQ_PUSH_FRONT, ile_pkg::REQ_APPEND: begin
              if (full) begin
                res_status_nxt = ile_pkg::STAT_FULL;
              end else begin
                cell_op  = ile_pkg::CELL_OPEN;
                cell_idx = (in_ch.req_type == ile_pkg::REQ_APPEND) ? IW'(count_r) : '0;
                res_status_nxt = ile_pkg::STAT_OK;
                res_idx_nxt    = cell_idx;
                count_nxt      = count_r + CW'(1);
              end
            end
            ile_pkg::REQ_INSERT: begin
              if (rp_ok && (rp <= pcnt)) begin
                if (full) begin
                  res_status_nxt = ile_pkg::STAT_FULL;
                end else begin
                  cell_op        = ile_pkg::CELL_OPEN;
                  cell_idx       = IW'(rp);
                  res_status_nxt = ile_pkg::STAT_OK;
                  res_idx_nxt    = IW'(rp);
                  count_nxt      = count_r + CW'(1);
                end
              end
            end
            ile_pkg::REQ_CHANGE: begin
              if (rp_ok && (rp < pcnt)) begin
                cell_op        = ile_pkg::CELL_WRITE;
                cell_idx       = IW'(rp);
                res_status_nxt = ile_pkg::STAT_OK;
                res_idx_nxt    = IW'(rp);
              end
            end
            ile_pkg::REQ_FIND: begin
              state_nxt = ST_SCAN;
            end
            ile_pkg::REQ_GET, ile_pkg::REQ_TAKE: begin
              if (rp_ok && (rp < pcnt)) begin
                idx_nxt   = IW'(rp);
                state_nxt = ST_SCAN;
              end
            end
            ile_pkg::REQ_POP: begin
              if (count_r != '0) begin
                idx_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: begin
        // rotate the ring by one; the head cell shows record scan_r
        cell_op  = ile_pkg::CELL_SHIFT_DOWN;
        cell_idx = '0;
        scan_nxt = scan_r + IW'(1);
        if (hit && !found_r) begin
          found_nxt      = 1'b1;
          res_status_nxt = ile_pkg::STAT_OK;
          res_idx_nxt    = scan_r;
          res_data_nxt   = head32;
        end
        if (scan_r == LAST_IDX) begin
          scan_nxt  = '0;
          state_nxt = ((req_r == ile_pkg::REQ_TAKE) || (req_r == ile_pkg::REQ_POP))
                      ? ST_CLOSE : ST_EMIT;
        end
      end
      ST_CLOSE: begin
        cell_op   = ile_pkg::CELL_SHIFT_DOWN;
        cell_idx  = idx_r;
        count_nxt = count_r - CW'(1);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (out_load) out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      kcm_r     <= 1'b0;
      scan_r    <= '0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      scan_r    <= scan_nxt;
      found_r   <= found_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) kcm_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_data_r   <= res_data_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= ile_pkg::RIDX_W'(res_idx_r);
      out_data_r   <= res_data_r;
      out_cnt_r    <= ile_pkg::CNT_W'(count_r);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.result_data  = out_data_r;
  assign out_ch.entry_count  = out_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("entry count beyond list depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("request beat accepted but sequencer stayed idle");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_status_r != ile_pkg::STAT_OK)) |->
      ((out_idx_r == '0) && (out_data_r == '0)))
    else $error("failed request carries index or data");

  a_close_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOSE) |-> (count_r != '0))
    else $error("gap close on empty list");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result beat raised outside emit");

endmodule

@@ sv/ile_cell.sv @@
`timescale 1ns / 1ps
// cell: holds a record; shift/open take a neighbor's, open/write take wr_data
// depends on ile_pkg for the cell command type
module ile_cell #(
  parameter int IDX_W        = 6,
  parameter int RECORD_WIDTH = 32,
  parameter int CELL_IDX     = 0
) (
  input  logic                    clk,
  input  ile_pkg::cell_op_t       op,
  input  logic [IDX_W-1:0]        sel_idx,
  input  logic [RECORD_WIDTH-1:0] wr_data,
  input  logic [RECORD_WIDTH-1:0] prev_rec,
  input  logic [RECORD_WIDTH-1:0] next_rec,
  output logic [RECORD_WIDTH-1:0] rec
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [RECORD_WIDTH-1:0] rec_r;
  logic [RECORD_WIDTH-1:0] rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    case (op)
      ile_pkg::CELL_SHIFT_DOWN: begin
        if (MY_IDX >= sel_idx) rec_nxt = next_rec;
      end
      ile_pkg::CELL_OPEN: begin
        if (MY_IDX > sel_idx) rec_nxt = prev_rec;
        else if (MY_IDX == sel_idx) rec_nxt = wr_data;
      end
      ile_pkg::CELL_WRITE: begin
        if (MY_IDX == sel_idx) rec_nxt = wr_data;
      end
      default: rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

@@ sim/indexed_list_engine_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for indexed_list_engine: directed and random requests with
// random stalls on both channels; a scoreboard class predicts every result beat
// depends on ile_pkg, ile_in_if, ile_out_if and the indexed_list_engine rtl
module indexed_list_engine_tb;
  import ile_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int RECORD_WIDTH = 32;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 150;

  localparam logic [PMODE_W-1:0] PMODE_EXPLICIT = 2'd0;
  localparam logic [PMODE_W-1:0] PMODE_SPARE    = 2'd3;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX, BURST_NOISE} burst_t;

  typedef struct {
    req_t                op;
    logic [PMODE_W-1:0]  pmode;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   data;
    logic [DATA_W-1:0]   key;
  } list_req_t;

  typedef struct {
    logic [STATUS_W-1:0] st;
    logic [RIDX_W-1:0]   idx;
    logic [DATA_W-1:0]   rdata;
    logic [CNT_W-1:0]    cnt;
  } list_resp_t;

  class list_scoreboard;
    logic [DATA_W-1:0] recs [LIST_DEPTH];
    int unsigned used;
    bit half_key;
    list_resp_t expected_q[$];
    int errors, n_req, n_full, n_miss, n_found, n_checked;

    function new();
      used = 0;
      half_key = 0;
      errors = 0;
      n_req = 0;
      n_full = 0;
      n_miss = 0;
      n_found = 0;
      n_checked = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit resolve(logic [PMODE_W-1:0] pm, logic [POS_W-1:0] p,
                         output int unsigned at);
      at = 0;
      if (pm == PMODE_FIRST) return 1'b1;
      if (pm == PMODE_LAST) begin
        if (used == 0) return 1'b0;
        at = used - 1;
        return 1'b1;
      end
      at = p;
      return 1'b1;
    endfunction

    function void open_slot(int unsigned at, logic [DATA_W-1:0] d);
      for (int unsigned i = used; i > at; i--) recs[i] = recs[i-1];
      recs[at] = d;
      used++;
    endfunction

    function void close_slot(int unsigned at);
      for (int unsigned i = at; i + 1 < used; i++) recs[i] = recs[i+1];
      used--;
    endfunction

    function void note_request(list_req_t r);
      list_resp_t e;
      int unsigned at;
      logic [DATA_W-1:0] km;
      e.st = STAT_NOT_IN_LIST;
      e.rdata = '0;
      at = 0;
      km = half_key ? {{(DATA_W-KEY_HALF_W){1'b0}}, {KEY_HALF_W{1'b1}}} : '1;
      case (r.op)
        REQ_PUSH_FRONT, REQ_APPEND: begin
          if (used >= LIST_DEPTH) begin
            e.st = STAT_FULL;
          end else begin
            at = (r.op == REQ_PUSH_FRONT) ? 0 : used;
            open_slot(at, r.data);
            e.st = STAT_OK;
          end
        end
        REQ_INSERT: begin
          if (resolve(r.pmode, r.pos, at) && at <= used) begin
            if (used >= LIST_DEPTH) begin
              e.st = STAT_FULL;
            end else begin
              open_slot(at, r.data);
              e.st = STAT_OK;
            end
          end
        end
        REQ_FIND: begin
          for (int unsigned i = 0; i < used; i++) begin
            if ((recs[i] & km) == (r.key & km)) begin
              at = i;
              e.rdata = recs[i];
              e.st = STAT_OK;
              break;
            end
          end
          if (e.st == STAT_OK) n_found++;
        end
        REQ_CHANGE: begin
          if (resolve(r.pmode, r.pos, at) && at < used) begin
            recs[at] = r.data;
            e.st = STAT_OK;
          end
        end
        REQ_GET: begin
          if (resolve(r.pmode, r.pos, at) && at < used) begin
            e.rdata = recs[at];
            e.st = STAT_OK;
          end
        end
        default: begin
          if (r.op == REQ_POP) begin
            at = 0;
            if (used > 0) e.st = STAT_OK;
          end else if (resolve(r.pmode, r.pos, at) && at < used) begin
            e.st = STAT_OK;
          end
          if (e.st == STAT_OK) begin
            e.rdata = recs[at];
            close_slot(at);
          end
        end
      endcase
      if (e.st != STAT_OK) begin
        at = 0;
        e.rdata = '0;
      end
      e.idx = RIDX_W'(at);
      e.cnt = CNT_W'(used);
      n_req++;
      if (e.st == STAT_FULL) n_full++;
      if (e.st == STAT_NOT_IN_LIST) n_miss++;
      expected_q.push_back(e);
    endfunction

    function void check_result(list_resp_t a);
      list_resp_t e;
      if (expected_q.size() == 0) begin
        $error("result beat arrived with no request outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (a.st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, a.st);
        errors++;
      end
      if (a.idx !== e.idx) begin
        $error("result_index: expected %0d, actual %0d", e.idx, a.idx);
        errors++;
      end
      if (a.rdata !== e.rdata) begin
        $error("result_data: expected %h, actual %h", e.rdata, a.rdata);
        errors++;
      end
      if (a.cnt !== e.cnt) begin
        $error("entry_count: expected %0d, actual %0d", e.cnt, a.cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  bit   gaps_on;
  int   cycles;
  list_scoreboard sb;

  ile_in_if  in_if ();
  ile_out_if out_if ();

  indexed_list_engine #(
    .LIST_DEPTH   (LIST_DEPTH),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic drive_request(list_req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.req_type      <= r.op;
    in_if.position_mode <= r.pmode;
    in_if.position      <= r.pos;
    in_if.entry_data    <= r.data;
    in_if.search_key    <= r.key;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic collect_results();
    int stall;
    list_resp_t a;
    @(negedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      a.st    = out_if.status;
      a.idx   = out_if.result_index;
      a.rdata = out_if.result_data;
      a.cnt   = out_if.entry_count;
      sb.check_result(a);
      @(negedge clk);
    end
  endtask

  // only while idle: every beat answered and the request channel quiet
  task automatic write_key_mode(bit m);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.half_key = m;
  endtask

  function automatic logic [DATA_W-1:0] stored_record();
    return sb.recs[$urandom_range(0, sb.used - 1)];
  endfunction

  function automatic list_req_t pick_request(burst_t kind);
    list_req_t r;
    int unsigned roll;
    logic [REQ_W-1:0] code;
    code = REQ_W'($urandom_range(0, 7));
    roll = $urandom_range(0, 9);
    case (kind)
      BURST_FILL:  r.op = (roll < 3) ? REQ_PUSH_FRONT : (roll < 6) ? REQ_APPEND :
                          (roll < 9) ? REQ_INSERT : req_t'(code);
      BURST_DRAIN: r.op = (roll < 4) ? REQ_POP : (roll < 8) ? REQ_TAKE :
                          (roll < 9) ? REQ_GET : req_t'(code);
      default:     r.op = req_t'(code);
    endcase
    if (kind == BURST_NOISE) begin
      r.pmode = PMODE_W'($urandom_range(0, 3));
      r.pos   = POS_W'($urandom_range(0, 127));
      r.data  = $urandom();
      r.key   = $urandom();
      return r;
    end
    roll = $urandom_range(0, 9);
    r.pmode = (roll < 6) ? PMODE_EXPLICIT : (roll == 6) ? PMODE_FIRST :
              (roll == 7) ? PMODE_LAST : (roll == 8) ? PMODE_SPARE : PMODE_EXPLICIT;
    roll = $urandom_range(0, 9);
    if (roll < 7)       r.pos = POS_W'($urandom_range(0, sb.used + 1));
    else if (roll == 7) r.pos = POS_W'(sb.used);
    else if (roll == 8) r.pos = POS_W'($urandom_range(64, 127));
    else                r.pos = POS_W'($urandom_range(0, 127));
    roll = $urandom_range(0, 9);
    if (roll == 0)                      r.data = '0;
    else if (roll == 1)                 r.data = '1;
    else if (roll < 4 && sb.used > 0)   r.data = stored_record();
    else                                r.data = $urandom();
    roll = $urandom_range(0, 9);
    if (roll < 6 && sb.used > 0) begin
      r.key = stored_record();
      if (sb.half_key && roll < 3)
        r.key[DATA_W-1:KEY_HALF_W] = (DATA_W-KEY_HALF_W)'($urandom());
    end else if (roll == 6) begin
      r.key = '0;
    end else begin
      r.key = $urandom();
    end
    return r;
  endfunction

  initial begin
    burst_t kind;
    int left;
    int unsigned roll;
    sb = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    gaps_on   = 1'b1;
    in_if.valid         = 1'b0;
    in_if.req_type      = REQ_PUSH_FRONT;
    in_if.position_mode = PMODE_EXPLICIT;
    in_if.position      = '0;
    in_if.entry_data    = '0;
    in_if.search_key    = '0;
    out_if.ready        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      collect_results();
    join_none
    @(negedge clk);

    write_key_mode(1'b0);
    // empty list corner cases
    drive_request('{REQ_POP,    PMODE_EXPLICIT, 7'd0,   32'h0,         32'h0});
    drive_request('{REQ_GET,    PMODE_LAST,     7'd0,   32'h0,         32'h0});
    drive_request('{REQ_FIND,   PMODE_EXPLICIT, 7'd0,   32'h0,         32'h0});
    drive_request('{REQ_CHANGE, PMODE_FIRST,    7'd0,   32'h1111_1111, 32'h0});
    drive_request('{REQ_TAKE,   PMODE_EXPLICIT, 7'd0,   32'h0,         32'h0});
    drive_request('{REQ_INSERT, PMODE_LAST,     7'd0,   32'h2222_2222, 32'h0});
    drive_request('{REQ_INSERT, PMODE_EXPLICIT, 7'd1,   32'h3333_3333, 32'h0});
    // build a short list through every add operation and mode, then read, change, find and remove in it
    drive_request('{REQ_INSERT, PMODE_EXPLICIT, 7'd0,   32'h0000_0000, 32'h0});
    drive_request('{REQ_PUSH_FRONT, PMODE_EXPLICIT, 7'd0, 32'hFFFF_FFFF, 32'h0});
    drive_request('{REQ_APPEND, PMODE_EXPLICIT, 7'd0,   32'hA5A5_1234, 32'h0});
    drive_request('{REQ_INSERT, PMODE_FIRST,    7'd0,   32'h0000_1234, 32'h0});
    drive_request('{REQ_INSERT, PMODE_LAST,     7'd0,   32'h8000_0001, 32'h0});
    drive_request('{REQ_INSERT, PMODE_SPARE,    7'd5,   32'h1234_1234, 32'h0});
    drive_request('{REQ_INSERT, PMODE_EXPLICIT, 7'd7,   32'h4444_4444, 32'h0});
    drive_request('{REQ_INSERT, PMODE_EXPLICIT, 7'd127, 32'h5555_5555, 32'h0});
    drive_request('{REQ_GET,    PMODE_LAST,     7'd0,   32'h0,         32'h0});
    drive_request('{REQ_GET,    PMODE_EXPLICIT, 7'd64,  32'h0,         32'h0});
    drive_request('{REQ_GET,    PMODE_SPARE,    7'd2,   32'h0,         32'h0});
    drive_request('{REQ_CHANGE, PMODE_LAST,     7'd0,   32'hDEAD_BEEF, 32'h0});
    drive_request('{REQ_FIND,   PMODE_EXPLICIT, 7'd0,   32'h0,         32'h0000_1234});
    drive_request('{REQ_FIND,   PMODE_EXPLICIT, 7'd0,   32'h0,         32'h0000_0001});
    drive_request('{REQ_TAKE,   PMODE_EXPLICIT, 7'd1,   32'h0,         32'h0});
    drive_request('{REQ_TAKE,   PMODE_FIRST,    7'd0,   32'h0,         32'h0});
    drive_request('{REQ_POP,    PMODE_LAST,     7'd3,   32'h0,         32'h0});
    write_key_mode(1'b1);
    drive_request('{REQ_FIND,   PMODE_EXPLICIT, 7'd0,   32'h0,         32'hFFFF_1234});
    drive_request('{REQ_FIND,   PMODE_EXPLICIT, 7'd0,   32'h0,         32'h0000_BEEF});

    left = 0;
    kind = BURST_MIX;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_key_mode(1'(ph % 2));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (left == 0) begin
          roll = $urandom_range(0, 19);
          kind = (roll < 6) ? BURST_FILL : (roll < 11) ? BURST_DRAIN :
                 (roll < 18) ? BURST_MIX : BURST_NOISE;
          left = $urandom_range(20, 90);
          gaps_on = ($urandom_range(0, 3) != 0);
        end
        drive_request(pick_request(kind));
        left--;
      end
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);
    $display("covered %0d requests over both key widths: %0d list full, %0d not in list,",
             sb.n_req, sb.n_full, sb.n_miss);
    $display("%0d find hits; %0d result beats checked, %0d mismatches",
             sb.n_found, sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
